// ===== design/pid_controller_antiwindup_unit_defines.svh =====
`ifndef PID_CONTROLLER_ANTIWINDUP_UNIT_DEFINES_SVH
`define PID_CONTROLLER_ANTIWINDUP_UNIT_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define PIDAW_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pidaw check failed");

// next-cycle implication
`define PIDAW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pidaw check failed");

// delayed implication
`define PIDAW_ASSERT_TWO(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##2 (cons)) \
        else $error("pidaw check failed");

`endif

// ===== design/pidaw_pkg.sv =====
`default_nettype none

package pidaw_pkg;

    localparam int SIGNAL_BITS    = 16;
    localparam int COEF_FRAC_BITS = 16;

    localparam int COEF_W     = 24;
    localparam int POLE_W     = 18;
    localparam int LIM_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int ERR_W       = SIGNAL_BITS + 1;
    localparam int INTEG_W     = LIM_W + COEF_FRAC_BITS;
    localparam int DERIV_W_RAW = SIGNAL_BITS + COEF_FRAC_BITS + 8;
    localparam int DERIV_W     = (DERIV_W_RAW > 63) ? 63 : DERIV_W_RAW;

    localparam int P_W     = COEF_W + ERR_W;
    localparam int ESUM_W  = ERR_W + 1;
    localparam int IPROD_W = COEF_W + ESUM_W;
    localparam int ISUM_W  = ((IPROD_W > INTEG_W) ? IPROD_W : INTEG_W) + 1;

    localparam int DPROD_W  = POLE_W + DERIV_W;
    localparam int DSH_W    = DPROD_W - COEF_FRAC_BITS;
    localparam int DCPROD_W = COEF_W + ERR_W;
    localparam int DMAX1_W  = (DSH_W > DCPROD_W) ? DSH_W : DCPROD_W;
    localparam int DSUM_W   = ((DMAX1_W > DERIV_W) ? DMAX1_W : DERIV_W) + 1;

    localparam int AMAX1_W = (P_W > INTEG_W) ? P_W : INTEG_W;
    localparam int ASUM_W  = ((AMAX1_W > DERIV_W) ? AMAX1_W : DERIV_W) + 2;

    localparam int IN_TDATA_W  = ((2 * SIGNAL_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((SIGNAL_BITS + 7) / 8) * 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN  = 3'd0,
        CFG_INTEG_COEF = 3'd1,
        CFG_DERIV_POLE = 3'd2,
        CFG_DERIV_COEF = 3'd3,
        CFG_OUT_MIN    = 3'd4,
        CFG_OUT_MAX    = 3'd5
    } t_cfg_idx;

    localparam logic signed [LIM_W-1:0] OUT_MIN_RESET = {1'b1, {(LIM_W-1){1'b0}}};
    localparam logic signed [LIM_W-1:0] OUT_MAX_RESET = {1'b0, {(LIM_W-1){1'b1}}};

endpackage

`default_nettype wire

// ===== design/pid_controller_antiwindup_unit.sv =====
// path: an input beat passes through the input register and then the result register
// throughput: one beat per cycle while the result side does not stall; the state update, combinational
// through the derivative multiply and the integral clamp, sets that figure
// reset (synchronous, active low): beats in flight dropped, history cleared,
// gains zero and limits at the full signal range
`default_nettype none

module pid_controller_antiwindup_unit
    import pidaw_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire [IN_TDATA_W-1:0]   s_axis_tdata,   // setpoint, measured
    input  wire                    s_axis_tuser,   // restart
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // control
    output logic                   m_axis_tuser,   // limited
    input  wire                    i_cfg_we,
    input  wire [CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]   i_cfg_data
);

    // configuration
    logic signed [COEF_W-1:0] r_prop_gain;
    logic signed [COEF_W-1:0] r_integ_coef;
    logic signed [POLE_W-1:0] r_deriv_pole;
    logic signed [COEF_W-1:0] r_deriv_coef;
    logic signed [LIM_W-1:0]  r_out_min;
    logic signed [LIM_W-1:0]  r_out_max;

    // history
    logic signed [SIGNAL_BITS-1:0] r_last_meas;
    logic signed [ERR_W-1:0]       r_last_err;
    logic signed [INTEG_W-1:0]     r_integ;
    logic signed [DERIV_W-1:0]     r_deriv;
    logic                          r_act_nonneg;
    logic                          r_act_nonpos;
    logic                          r_last_lim;

    // input stage
    logic                          r_in_vld;
    logic signed [SIGNAL_BITS-1:0] r_sp;
    logic signed [SIGNAL_BITS-1:0] r_pv;
    logic                          r_restart;

    // result stage
    logic                          r_out_vld;
    logic signed [SIGNAL_BITS-1:0] r_control;
    logic                          r_limited;

    logic out_adv;
    logic step;

    logic signed [SIGNAL_BITS-1:0] lm;
    logic signed [ERR_W-1:0]       le;
    logic signed [INTEG_W-1:0]     it;
    logic signed [DERIV_W-1:0]     dt;
    logic signed [ERR_W-1:0]       e;
    logic signed [P_W-1:0]         p;
    logic signed [ESUM_W-1:0]      esum;
    logic signed [IPROD_W-1:0]     iprod;
    logic signed [ISUM_W-1:0]      isum;
    logic signed [INTEG_W-1:0]     lo;
    logic signed [INTEG_W-1:0]     hi;
    logic signed [INTEG_W-1:0]     integ_new;
    logic signed [INTEG_W-1:0]     n_integ;
    logic                          hold;
    logic signed [DPROD_W-1:0]     dprod;
    logic signed [DSH_W-1:0]       dsh;
    logic signed [ERR_W-1:0]       dmeas;
    logic signed [DCPROD_W-1:0]    dcprod;
    logic signed [DSUM_W-1:0]      dsum;
    logic signed [DERIV_W-1:0]     n_deriv;
    logic signed [ASUM_W-1:0]      act;
    logic                          act_hi;
    logic                          act_lo;
    logic signed [INTEG_W-1:0]     lim_act;
    logic signed [SIGNAL_BITS-1:0] n_control;

    localparam logic signed [DSUM_W-1:0] DERIV_HI =
        {{(DSUM_W-DERIV_W+1){1'b0}}, {(DERIV_W-1){1'b1}}};
    localparam logic signed [DSUM_W-1:0] DERIV_LO = ~DERIV_HI;

    assign out_adv       = !r_out_vld || m_axis_tready;
    assign step          = r_in_vld && out_adv;
    assign s_axis_tready = !r_in_vld || out_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= '0;
            r_integ_coef <= '0;
            r_deriv_pole <= '0;
            r_deriv_coef <= '0;
            r_out_min    <= OUT_MIN_RESET;
            r_out_max    <= OUT_MAX_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PROP_GAIN:  r_prop_gain  <= signed'(i_cfg_data[COEF_W-1:0]);
                CFG_INTEG_COEF: r_integ_coef <= signed'(i_cfg_data[COEF_W-1:0]);
                CFG_DERIV_POLE: r_deriv_pole <= signed'(i_cfg_data[POLE_W-1:0]);
                CFG_DERIV_COEF: r_deriv_coef <= signed'(i_cfg_data[COEF_W-1:0]);
                CFG_OUT_MIN:    r_out_min    <= signed'(i_cfg_data[LIM_W-1:0]);
                CFG_OUT_MAX:    r_out_max    <= signed'(i_cfg_data[LIM_W-1:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        // restart clears history ahead of this sample
        lm = r_restart ? '0 : r_last_meas;
        le = r_restart ? '0 : r_last_err;
        it = r_restart ? '0 : r_integ;
        dt = r_restart ? '0 : r_deriv;

        e = ERR_W'(r_sp) - ERR_W'(r_pv);
        p = P_W'(r_prop_gain) * P_W'(e);

        lo = signed'({r_out_min, {COEF_FRAC_BITS{1'b0}}});
        hi = signed'({r_out_max, {COEF_FRAC_BITS{1'b0}}});

        // trapezoidal integral, clamped to the limits
        esum  = ESUM_W'(e) + ESUM_W'(le);
        iprod = IPROD_W'(r_integ_coef) * IPROD_W'(esum);
        isum  = ISUM_W'(iprod) + ISUM_W'(it);
        if (isum > ISUM_W'(hi)) begin
            integ_new = hi;
        end else if (isum < ISUM_W'(lo)) begin
            integ_new = lo;
        end else begin
            integ_new = INTEG_W'(isum);
        end

        // anti-windup hold
        hold = r_last_lim &&
               ((r_act_nonneg && !e[ERR_W-1]) ||
                (r_act_nonpos && (e[ERR_W-1] || e == '0)));
        n_integ = hold ? it : integ_new;

        // filtered derivative of the measurement
        dprod  = DPROD_W'(r_deriv_pole) * DPROD_W'(dt);
        dsh    = signed'(dprod[DPROD_W-1:COEF_FRAC_BITS]);
        dmeas  = ERR_W'(r_pv) - ERR_W'(lm);
        dcprod = DCPROD_W'(r_deriv_coef) * DCPROD_W'(dmeas);
        dsum   = DSUM_W'(dsh) + DSUM_W'(dcprod);
        if (dsum > DERIV_HI) begin
            n_deriv = DERIV_W'(DERIV_HI);
        end else if (dsum < DERIV_LO) begin
            n_deriv = DERIV_W'(DERIV_LO);
        end else begin
            n_deriv = DERIV_W'(dsum);
        end

        // summed action and output limit
        act    = ASUM_W'(p) + ASUM_W'(n_integ) + ASUM_W'(n_deriv);
        act_hi = act > ASUM_W'(hi);
        act_lo = act < ASUM_W'(lo);
        if (act_hi) begin
            lim_act = hi;
        end else if (act_lo) begin
            lim_act = lo;
        end else begin
            lim_act = INTEG_W'(act);
        end
        n_control = SIGNAL_BITS'(signed'(lim_act[INTEG_W-1:COEF_FRAC_BITS]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_last_meas  <= '0;
            r_last_err   <= '0;
            r_integ      <= '0;
            r_deriv      <= '0;
            r_act_nonneg <= 1'b1;
            r_act_nonpos <= 1'b1;
            r_last_lim   <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_vld <= s_axis_tvalid;
            end
            if (out_adv) begin
                r_out_vld <= r_in_vld;
            end
            if (step) begin
                r_last_meas  <= r_pv;
                r_last_err   <= e;
                r_integ      <= n_integ;
                r_deriv      <= n_deriv;
                r_act_nonneg <= !act[ASUM_W-1];
                r_act_nonpos <= act[ASUM_W-1] || (act == '0);
                r_last_lim   <= act_hi || act_lo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_sp      <= signed'(s_axis_tdata[SIGNAL_BITS-1:0]);
            r_pv      <= signed'(s_axis_tdata[2*SIGNAL_BITS-1:SIGNAL_BITS]);
            r_restart <= s_axis_tuser;
        end
        if (step) begin
            r_control <= n_control;
            r_limited <= act_hi || act_lo;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OUT_TDATA_W'(unsigned'(r_control));
    assign m_axis_tuser  = r_limited;

endmodule

`default_nettype wire

// ===== design/pidaw_checker.sv =====
`default_nettype none

`include "pid_controller_antiwindup_unit_defines.svh"

module pidaw_checker
    import pidaw_pkg::*;
(
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   s_axis_tvalid,
    input wire                   s_axis_tready,
    input wire                   m_axis_tvalid,
    input wire                   m_axis_tready,
    input wire [OUT_TDATA_W-1:0] m_axis_tdata,   // control
    input wire                   m_axis_tuser    // limited
);

    // a stalled result beat holds
    `PIDAW_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // an empty result register never blocks the input
    `PIDAW_ASSERT_NOW(a_in_free, !m_axis_tvalid, s_axis_tready)

    // every input beat taken is followed by a valid beat on the result side
    `PIDAW_ASSERT_TWO(a_latency, s_axis_tvalid && s_axis_tready, m_axis_tvalid)

    // nothing comes out of the first cycle after reset
    `PIDAW_ASSERT_NEXT(a_quiet, $rose(i_rst_n), !m_axis_tvalid)

endmodule

bind pid_controller_antiwindup_unit pidaw_checker u_pidaw_checker (.*);

`default_nettype wire

// ===== verif/pidaw_checker.sv =====
`timescale 1ns / 100ps

module pidaw_scoreboard
    import pidaw_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_s_tvalid,
    input  wire                    i_s_tready,
    input  wire [IN_TDATA_W-1:0]   i_s_tdata,   // setpoint, measured
    input  wire                    i_s_tuser,   // restart
    input  wire                    i_m_tvalid,
    input  wire                    i_m_tready,
    input  wire [OUT_TDATA_W-1:0]  i_m_tdata,   // control
    input  wire                    i_m_tuser,   // limited
    input  wire                    i_cfg_we,
    input  wire [CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]   i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending
);

    localparam int ACT_W_RAW = SIGNAL_BITS + COEF_FRAC_BITS + 16;
    localparam int ACT_W     = (ACT_W_RAW > 63) ? 63 : ACT_W_RAW;

    typedef struct packed {
        logic [SIGNAL_BITS-1:0] control;
        logic                   limited;
    } t_pid_result;

    longint      prop_k, integ_k, pole_k, deriv_k, lim_lo, lim_hi;
    longint      prev_meas, prev_err, integ_acc, deriv_acc, prev_action;
    bit          prev_clipped;
    t_pid_result action_q[$];
    int          mismatches = 0;
    int          result_beats = 0;

    function automatic longint sat_signed(longint v, int w);
        longint top;
        top = (64'sd1 <<< (w - 1)) - 1;
        if (v > top) return top;
        if (v < -top - 1) return -top - 1;
        return v;
    endfunction

    // with crossed limits, a value above hi gives hi, any other gives lo
    function automatic longint clamp_range(longint v, longint lo, longint hi);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic t_pid_result predict_pid(longint sp, longint pv, bit restart);
        longint      lo, hi, err, prop, integ, deriv, act, held, whole;
        bit          hold;
        t_pid_result r;
        lo = lim_lo <<< COEF_FRAC_BITS;
        hi = lim_hi <<< COEF_FRAC_BITS;
        if (restart) begin
            prev_meas = 0;
            prev_err  = 0;
            integ_acc = 0;
            deriv_acc = 0;
        end
        err  = sp - pv;
        prop = prop_k * err;
        // anti-windup: freeze the integral while pushing further into the limit
        hold = prev_clipped &&
               ((prev_action >= 0 && err >= 0) || (prev_action <= 0 && err <= 0));
        integ = hold ? integ_acc : clamp_range(integ_acc + integ_k * (err + prev_err), lo, hi);
        deriv = sat_signed(((pole_k * deriv_acc) >>> COEF_FRAC_BITS)
                           + deriv_k * (pv - prev_meas), DERIV_W);
        act   = sat_signed(prop + integ + deriv, ACT_W);
        held  = clamp_range(act, lo, hi);
        whole = held >>> COEF_FRAC_BITS;
        prev_action  = act;
        prev_clipped = (held != act);
        prev_meas    = pv;
        prev_err     = err;
        integ_acc    = integ;
        deriv_acc    = deriv;
        r.control = whole[SIGNAL_BITS-1:0];
        r.limited = prev_clipped;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: result beat %0d: %s got %0d expected %0d",
                 $time, result_beats, what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : watch
        t_pid_result want;
        if (!i_rst_n) begin
            prop_k       = 0;
            integ_k      = 0;
            pole_k       = 0;
            deriv_k      = 0;
            lim_lo       = OUT_MIN_RESET;
            lim_hi       = OUT_MAX_RESET;
            prev_meas    = 0;
            prev_err     = 0;
            integ_acc    = 0;
            deriv_acc    = 0;
            prev_action  = 0;
            prev_clipped = 1'b0;
            action_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PROP_GAIN:  prop_k  = $signed(i_cfg_data[COEF_W-1:0]);
                    CFG_INTEG_COEF: integ_k = $signed(i_cfg_data[COEF_W-1:0]);
                    CFG_DERIV_POLE: pole_k  = $signed(i_cfg_data[POLE_W-1:0]);
                    CFG_DERIV_COEF: deriv_k = $signed(i_cfg_data[COEF_W-1:0]);
                    CFG_OUT_MIN:    lim_lo  = $signed(i_cfg_data[LIM_W-1:0]);
                    CFG_OUT_MAX:    lim_hi  = $signed(i_cfg_data[LIM_W-1:0]);
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                action_q.push_back(predict_pid($signed(i_s_tdata[SIGNAL_BITS-1:0]),
                                               $signed(i_s_tdata[2*SIGNAL_BITS-1:SIGNAL_BITS]),
                                               i_s_tuser));
            if (i_m_tvalid && i_m_tready) begin
                if (action_q.size() == 0) begin
                    report_mismatch("unexpected beat, control",
                                    $signed(i_m_tdata[SIGNAL_BITS-1:0]), 0);
                end else begin
                    want = action_q.pop_front();
                    if (i_m_tdata[SIGNAL_BITS-1:0] !== want.control)
                        report_mismatch("control", $signed(i_m_tdata[SIGNAL_BITS-1:0]),
                                        $signed(want.control));
                    if (i_m_tuser !== want.limited)
                        report_mismatch("limited", i_m_tuser, want.limited);
                end
                result_beats++;
            end
        end
        o_pending    <= action_q.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import pidaw_pkg::*;

    localparam int     CYCLE_LIMIT   = 200000;
    localparam int     SETTLE_CYCLES = 6;
    localparam int     HOLD_CYCLES   = 400;
    localparam longint ONE_Q    = 64'sd1 <<< COEF_FRAC_BITS;
    localparam longint SIG_MAX  = (64'sd1 <<< (SIGNAL_BITS - 1)) - 1;
    localparam longint SIG_MIN  = -SIG_MAX - 1;
    localparam longint COEF_MAX = (64'sd1 <<< (COEF_W - 1)) - 1;
    localparam longint COEF_MIN = -COEF_MAX - 1;
    localparam longint POLE_MAX = (64'sd1 <<< (POLE_W - 1)) - 1;
    localparam longint POLE_MIN = -POLE_MAX - 1;
    localparam longint LIM_MAX  = (64'sd1 <<< (LIM_W - 1)) - 1;
    localparam longint LIM_MIN  = -LIM_MAX - 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(CFG_OUT_MAX + 1);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(CFG_OUT_MAX + 2);

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // setpoint, measured
    logic                   s_axis_tuser;   // restart
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // control
    logic                   m_axis_tuser;   // limited
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    int     fail_count;
    int     pending;
    int     cycles = 0;
    bit     gaps_on;
    bit     stall_req;
    longint track_sp, track_pv;

    pid_controller_antiwindup_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    pidaw_scoreboard chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver, with one long hold-off on request
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                stall_req = 1'b0;
            end
            m_axis_tready <= !gaps_on || ($urandom_range(99) >= 15);
        end
    end

    function automatic longint pick(longint lo, longint hi);
        return lo + longint'($urandom_range(32'(hi - lo)));
    endfunction

    function automatic longint pick_coef(longint span, longint lo, longint hi);
        int roll;
        roll = $urandom_range(99);
        if (roll < 8) return lo;
        if (roll < 16) return hi;
        return pick(-span, span);
    endfunction

    function automatic longint clip_sig(longint v);
        if (v > SIG_MAX) return SIG_MAX;
        if (v < SIG_MIN) return SIG_MIN;
        return v;
    endfunction

    task automatic send_sample(input longint sp, input longint pv, input bit restart);
        while (gaps_on && $urandom_range(99) < 15) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pv[SIGNAL_BITS-1:0], sp[SIGNAL_BITS-1:0]};
        s_axis_tuser  <= restart;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // unused upper data bits carry junk
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint value,
                             input int width);
        logic [CFG_DATA_W-1:0] mask;
        logic [CFG_DATA_W-1:0] junk;
        mask = CFG_DATA_W'((64'd1 << width) - 1);
        junk = CFG_DATA_W'($urandom);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= (junk & ~mask) | (CFG_DATA_W'(value) & mask);
        @(posedge i_clk);
    endtask

    task automatic program_regs(input longint kp, ki, pole, kd, lo, hi);
        write_reg(CFG_PROP_GAIN, kp, COEF_W);
        write_reg(CFG_INTEG_COEF, ki, COEF_W);
        write_reg(CFG_DERIV_POLE, pole, POLE_W);
        write_reg(CFG_DERIV_COEF, kd, COEF_W);
        write_reg(CFG_OUT_MIN, lo, LIM_W);
        write_reg(CFG_OUT_MAX, hi, LIM_W);
        write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, longint'($urandom),
                  CFG_DATA_W);
        i_cfg_we <= 1'b0;
    endtask

    task automatic pick_settings();
        longint lo, hi;
        int     roll;
        roll = $urandom_range(99);
        if (roll < 10) begin
            lo = LIM_MIN;
            hi = LIM_MAX;
        end else if (roll < 20) begin
            lo = pick(1, 3000);
            hi = pick(-3000, 0);
        end else begin
            lo = pick(-20000, 0);
            hi = pick(0, 20000);
        end
        program_regs(pick_coef(3 * ONE_Q, COEF_MIN, COEF_MAX),
                     pick_coef(ONE_Q / 8, COEF_MIN, COEF_MAX),
                     pick_coef(ONE_Q, POLE_MIN, POLE_MAX),
                     pick_coef(2 * ONE_Q, COEF_MIN, COEF_MAX), lo, hi);
    endtask

    // mostly a plant tracking a held setpoint, some raw noise
    task automatic run_phase(input int count);
        longint sp, pv;
        bit     restart;
        int     roll;
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(99);
            if (roll < 15) begin
                sp      = pick(SIG_MIN, SIG_MAX);
                pv      = pick(SIG_MIN, SIG_MAX);
                restart = $urandom_range(1);
            end else begin
                if (roll < 19) track_sp = pick(SIG_MIN / 2, SIG_MAX / 2);
                track_pv = clip_sig(track_pv + ((track_sp - track_pv) >>> 3) + pick(-150, 150));
                sp       = track_sp;
                pv       = track_pv;
                restart  = ($urandom_range(99) < 3);
            end
            send_sample(sp, pv, restart);
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        gaps_on   = 1'b1;
        stall_req = 1'b0;
        track_sp  = 0;
        track_pv  = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // settings straight out of reset
        send_sample(0, 0, 0);
        send_sample(SIG_MAX, SIG_MIN, 0);
        send_sample(SIG_MIN, SIG_MAX, 1);
        wait_idle();

        // saturation, integral hold and release, restart, negative floor
        program_regs(2 * ONE_Q, 6554, ONE_Q / 2, 13107, -1000, 1000);
        send_sample(SIG_MAX, SIG_MIN, 0);
        send_sample(1000, 0, 0);
        send_sample(-500, 0, 0);
        send_sample(0, 0, 0);
        send_sample(SIG_MIN, SIG_MAX, 0);
        send_sample(0, 0, 1);
        send_sample(3, 5, 0);
        send_sample(-1, 0, 1);
        send_sample(200, 150, 0);
        wait_idle();

        // crossed limits
        program_regs(ONE_Q, ONE_Q / 4, 0, ONE_Q, 500, -500);
        send_sample(0, 0, 1);
        send_sample(SIG_MAX, 0, 0);
        send_sample(SIG_MIN, 0, 0);
        send_sample(10, 10, 0);
        wait_idle();

        // extreme gains, unstable pole driving the derivative into saturation
        program_regs(COEF_MIN, COEF_MAX, POLE_MAX, COEF_MAX, LIM_MIN, LIM_MAX);
        send_sample(SIG_MAX, SIG_MIN, 0);
        send_sample(SIG_MIN, SIG_MAX, 0);
        send_sample(SIG_MAX, SIG_MIN, 0);
        send_sample(SIG_MIN, SIG_MAX, 0);
        wait_idle();

        program_regs(COEF_MAX, COEF_MIN, POLE_MIN, COEF_MIN, LIM_MAX, LIM_MAX);
        send_sample(SIG_MIN, SIG_MAX, 0);
        send_sample(SIG_MAX, SIG_MIN, 0);
        send_sample(SIG_MAX, SIG_MAX, 0);

        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            pick_settings();
            gaps_on = (ph != 2) && (ph != 5);
            if (ph == 5) stall_req = 1'b1;
            if (ph == 6) begin
                run_phase(55);
                wait_idle();
                run_phase(60);
            end else begin
                run_phase(115);
            end
        end
        wait_idle();

        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
